>>> rtl/core/rv32id_pkg.sv
// Package for the RV32I instruction decoder: opcodes, operation numbers,
// funct3 lookup functions and shared types. No dependencies.
package rv32id_pkg;

   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_FENCE  = 7'b0001111;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

   localparam logic [6:0]  F7_BASE     = 7'b0000000;
   localparam logic [6:0]  F7_ALT      = 7'b0100000;
   localparam logic [24:0] SYS_ECALL   = 25'h0000000;
   localparam logic [24:0] SYS_EBREAK  = 25'h0002000;

   localparam logic [5:0] OP_LB     = 6'd0;
   localparam logic [5:0] OP_LH     = 6'd1;
   localparam logic [5:0] OP_LW     = 6'd2;
   localparam logic [5:0] OP_LBU    = 6'd3;
   localparam logic [5:0] OP_LHU    = 6'd4;
   localparam logic [5:0] OP_FENCE  = 6'd5;
   localparam logic [5:0] OP_ADDI   = 6'd6;
   localparam logic [5:0] OP_SLTI   = 6'd7;
   localparam logic [5:0] OP_SLTIU  = 6'd8;
   localparam logic [5:0] OP_XORI   = 6'd9;
   localparam logic [5:0] OP_ORI    = 6'd10;
   localparam logic [5:0] OP_ANDI   = 6'd11;
   localparam logic [5:0] OP_AUIPC  = 6'd12;
   localparam logic [5:0] OP_SB     = 6'd13;
   localparam logic [5:0] OP_SH     = 6'd14;
   localparam logic [5:0] OP_SW     = 6'd15;
   localparam logic [5:0] OP_ADD    = 6'd16;
   localparam logic [5:0] OP_SLL    = 6'd17;
   localparam logic [5:0] OP_SLT    = 6'd18;
   localparam logic [5:0] OP_SLTU   = 6'd19;
   localparam logic [5:0] OP_XOR    = 6'd20;
   localparam logic [5:0] OP_SRL    = 6'd21;
   localparam logic [5:0] OP_OR     = 6'd22;
   localparam logic [5:0] OP_AND    = 6'd23;
   localparam logic [5:0] OP_SUB    = 6'd24;
   localparam logic [5:0] OP_SRA    = 6'd25;
   localparam logic [5:0] OP_LUI    = 6'd26;
   localparam logic [5:0] OP_BEQ    = 6'd27;
   localparam logic [5:0] OP_BNE    = 6'd28;
   localparam logic [5:0] OP_BLT    = 6'd29;
   localparam logic [5:0] OP_BGE    = 6'd30;
   localparam logic [5:0] OP_BLTU   = 6'd31;
   localparam logic [5:0] OP_BGEU   = 6'd32;
   localparam logic [5:0] OP_JALR   = 6'd33;
   localparam logic [5:0] OP_JAL    = 6'd34;
   localparam logic [5:0] OP_ECALL  = 6'd35;
   localparam logic [5:0] OP_EBREAK = 6'd36;
   localparam logic [5:0] OP_LAST   = OP_EBREAK;

   typedef struct packed {
      logic       hit;
      logic [5:0] op;
   } op_lookup_type;

   typedef struct packed {
      logic [31:0] imm_i;
      logic [31:0] imm_s;
      logic [31:0] imm_b;
      logic [31:0] imm_u;
      logic [31:0] imm_j;
      logic [31:0] imm_fence;
   } imm_set_type;

   typedef struct packed {
      logic [5:0]  op_id;
      logic        illegal;
      logic [4:0]  dest_reg;
      logic [4:0]  src_reg_a;
      logic [4:0]  src_reg_b;
      logic [31:0] immediate;
   } decode_result_type;

   localparam op_lookup_type NO_HIT = '{hit: 1'b0, op: 6'd0};

   function automatic op_lookup_type hit_op(input logic [5:0] op);
      op_lookup_type r;
      r.hit = 1'b1;
      r.op  = op;
      return r;
   endfunction

   function automatic op_lookup_type load_op(input logic [2:0] f3);
      case (f3)
         3'd0:    return hit_op(OP_LB);
         3'd1:    return hit_op(OP_LH);
         3'd2:    return hit_op(OP_LW);
         3'd4:    return hit_op(OP_LBU);
         3'd5:    return hit_op(OP_LHU);
         default: return NO_HIT;
      endcase
   endfunction

   function automatic op_lookup_type opimm_op(input logic [2:0] f3);
      case (f3)
         3'd0:    return hit_op(OP_ADDI);
         3'd2:    return hit_op(OP_SLTI);
         3'd3:    return hit_op(OP_SLTIU);
         3'd4:    return hit_op(OP_XORI);
         3'd6:    return hit_op(OP_ORI);
         3'd7:    return hit_op(OP_ANDI);
         default: return NO_HIT;
      endcase
   endfunction

   function automatic op_lookup_type store_op(input logic [2:0] f3);
      case (f3)
         3'd0:    return hit_op(OP_SB);
         3'd1:    return hit_op(OP_SH);
         3'd2:    return hit_op(OP_SW);
         default: return NO_HIT;
      endcase
   endfunction

   function automatic op_lookup_type reg_op(input logic [2:0] f3, input logic [6:0] f7);
      op_lookup_type r;
      r = NO_HIT;
      if (f7 == F7_BASE) begin
         case (f3)
            3'd0:    r = hit_op(OP_ADD);
            3'd1:    r = hit_op(OP_SLL);
            3'd2:    r = hit_op(OP_SLT);
            3'd3:    r = hit_op(OP_SLTU);
            3'd4:    r = hit_op(OP_XOR);
            3'd5:    r = hit_op(OP_SRL);
            3'd6:    r = hit_op(OP_OR);
            default: r = hit_op(OP_AND);
         endcase
      end else if (f7 == F7_ALT) begin
         case (f3)
            3'd0:    r = hit_op(OP_SUB);
            3'd5:    r = hit_op(OP_SRA);
            default: r = NO_HIT;
         endcase
      end
      return r;
   endfunction

   function automatic op_lookup_type branch_op(input logic [2:0] f3);
      case (f3)
         3'd0:    return hit_op(OP_BEQ);
         3'd1:    return hit_op(OP_BNE);
         3'd4:    return hit_op(OP_BLT);
         3'd5:    return hit_op(OP_BGE);
         3'd6:    return hit_op(OP_BLTU);
         3'd7:    return hit_op(OP_BGEU);
         default: return NO_HIT;
      endcase
   endfunction

endpackage

>>> rtl/core/rv32i_instruction_decoder_top.sv
// Top level of the RV32I instruction decoder: request register, decode,
// result register. Depends on rv32id_pkg and rv32id_decode.
// Throughput: one request per cycle; busy is never raised.
// Reset: synchronous, clears the request and result strobes; no results pending.
// The receiver cannot stall: each result is shown for one cycle on rsp_strobe.
module rv32i_instruction_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_instr_word,
   output logic               rsp_strobe,
   output logic [5:0]         rsp_op_id,
   output logic               rsp_illegal,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src_reg_a,
   output logic [4:0]         rsp_src_reg_b,
   output logic signed [31:0] rsp_immediate
);

   logic                          req_valid_ff;
   logic                          req_valid_in;
   logic [31:0]                   req_word_ff;
   logic                          rsp_valid_ff;
   rv32id_pkg::decode_result_type rsp_ff;
   rv32id_pkg::decode_result_type dec_result;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_word_ff <= req_instr_word;
      end
      if (req_valid_ff) begin
         rsp_ff <= dec_result;
      end
   end

   rv32id_decode u_decode (
      .instr_word (req_word_ff),
      .result     (dec_result)
   );

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_op_id     = rsp_ff.op_id;
   assign rsp_illegal   = rsp_ff.illegal;
   assign rsp_dest_reg  = rsp_ff.dest_reg;
   assign rsp_src_reg_a = rsp_ff.src_reg_a;
   assign rsp_src_reg_b = rsp_ff.src_reg_b;
   assign rsp_immediate = $signed(rsp_ff.immediate);

   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("request not answered two cycles later");

   a_no_spurious_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(req_valid_ff))
      else $error("result strobe without a decoded request");

   a_illegal_zeroed : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_illegal) |-> (rsp_op_id == 6'd0 && rsp_dest_reg == 5'd0 &&
         rsp_src_reg_a == 5'd0 && rsp_src_reg_b == 5'd0 && rsp_immediate == 32'sd0))
      else $error("illegal result with non-zero fields");

   a_op_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_op_id <= rv32id_pkg::OP_LAST))
      else $error("operation number out of range");

endmodule

>>> rtl/core/rv32id_imm_gen.sv
// Immediate assembly for every RV32I format from one instruction word.
// Depends on rv32id_pkg.
module rv32id_imm_gen (
   input  logic [31:0]               instr_word,
   output rv32id_pkg::imm_set_type   imm_set
);

   logic sign;

   assign sign = instr_word[31];

   always_comb begin
      imm_set.imm_i     = {{21{sign}}, instr_word[30:20]};
      imm_set.imm_s     = {{21{sign}}, instr_word[30:25], instr_word[11:7]};
      imm_set.imm_b     = {{20{sign}}, instr_word[7], instr_word[30:25],
                           instr_word[11:8], 1'b0};
      imm_set.imm_u     = {instr_word[31:12], 12'd0};
      imm_set.imm_j     = {{12{sign}}, instr_word[19:12], instr_word[20],
                           instr_word[30:21], 1'b0};
      imm_set.imm_fence = {20'd0, instr_word[31:20]};
   end

endmodule

>>> rtl/core/rv32id_decode.sv
// Opcode/funct decode and field selection for one instruction word.
// Depends on rv32id_pkg and rv32id_imm_gen.
module rv32id_decode (
   input  logic [31:0]                     instr_word,
   output rv32id_pkg::decode_result_type   result
);

   rv32id_pkg::imm_set_type   imm_set;
   rv32id_pkg::op_lookup_type lookup;
   logic [6:0] opc;
   logic [2:0] f3;
   logic [6:0] f7;
   logic [4:0] rd;
   logic [4:0] rs1;
   logic [4:0] rs2;
   logic [4:0] sel_rd;
   logic [4:0] sel_rs1;
   logic [4:0] sel_rs2;
   logic [31:0] sel_imm;

   rv32id_imm_gen u_imm_gen (
      .instr_word (instr_word),
      .imm_set    (imm_set)
   );

   assign opc = instr_word[6:0];
   assign f3  = instr_word[14:12];
   assign f7  = instr_word[31:25];
   assign rd  = instr_word[11:7];
   assign rs1 = instr_word[19:15];
   assign rs2 = instr_word[24:20];

   always_comb begin
      lookup  = rv32id_pkg::NO_HIT;
      sel_rd  = 5'd0;
      sel_rs1 = 5'd0;
      sel_rs2 = 5'd0;
      sel_imm = 32'd0;
      case (opc)
         rv32id_pkg::OPC_LOAD: begin
            lookup  = rv32id_pkg::load_op(f3);
            sel_rd  = rd;
            sel_rs1 = rs1;
            sel_imm = imm_set.imm_i;
         end
         rv32id_pkg::OPC_FENCE: begin
            if (f3 == 3'd0) begin
               lookup = rv32id_pkg::hit_op(rv32id_pkg::OP_FENCE);
            end
            sel_rd  = rd;
            sel_rs1 = rs1;
            sel_imm = imm_set.imm_fence;
         end
         rv32id_pkg::OPC_OPIMM: begin
            lookup  = rv32id_pkg::opimm_op(f3);
            sel_rd  = rd;
            sel_rs1 = rs1;
            sel_imm = imm_set.imm_i;
         end
         rv32id_pkg::OPC_AUIPC: begin
            lookup  = rv32id_pkg::hit_op(rv32id_pkg::OP_AUIPC);
            sel_rd  = rd;
            sel_imm = imm_set.imm_u;
         end
         rv32id_pkg::OPC_STORE: begin
            lookup  = rv32id_pkg::store_op(f3);
            sel_rs1 = rs1;
            sel_rs2 = rs2;
            sel_imm = imm_set.imm_s;
         end
         rv32id_pkg::OPC_OP: begin
            lookup  = rv32id_pkg::reg_op(f3, f7);
            sel_rd  = rd;
            sel_rs1 = rs1;
            sel_rs2 = rs2;
         end
         rv32id_pkg::OPC_LUI: begin
            lookup  = rv32id_pkg::hit_op(rv32id_pkg::OP_LUI);
            sel_rd  = rd;
            sel_imm = imm_set.imm_u;
         end
         rv32id_pkg::OPC_BRANCH: begin
            lookup  = rv32id_pkg::branch_op(f3);
            sel_rs1 = rs1;
            sel_rs2 = rs2;
            sel_imm = imm_set.imm_b;
         end
         rv32id_pkg::OPC_JALR: begin
            lookup  = rv32id_pkg::hit_op(rv32id_pkg::OP_JALR);
            sel_rd  = rd;
            sel_rs1 = rs1;
            sel_imm = imm_set.imm_i;
         end
         rv32id_pkg::OPC_JAL: begin
            lookup  = rv32id_pkg::hit_op(rv32id_pkg::OP_JAL);
            sel_rd  = rd;
            sel_imm = imm_set.imm_j;
         end
         rv32id_pkg::OPC_SYSTEM: begin
            if (instr_word[31:7] == rv32id_pkg::SYS_ECALL) begin
               lookup = rv32id_pkg::hit_op(rv32id_pkg::OP_ECALL);
            end else if (instr_word[31:7] == rv32id_pkg::SYS_EBREAK) begin
               lookup = rv32id_pkg::hit_op(rv32id_pkg::OP_EBREAK);
            end
         end
         default: begin
            lookup = rv32id_pkg::NO_HIT;
         end
      endcase
   end

   // unmatched encodings: flag only, everything else zero
   always_comb begin
      if (lookup.hit) begin
         result.op_id     = lookup.op;
         result.illegal   = 1'b0;
         result.dest_reg  = sel_rd;
         result.src_reg_a = sel_rs1;
         result.src_reg_b = sel_rs2;
         result.immediate = sel_imm;
      end else begin
         result.op_id     = 6'd0;
         result.illegal   = 1'b1;
         result.dest_reg  = 5'd0;
         result.src_reg_a = 5'd0;
         result.src_reg_b = 5'd0;
         result.immediate = 32'd0;
      end
   end

endmodule
